// ===== rtl/core/ilt_pkg.sv =====
// shared types and constants for the i/o request latency tracker
// depends on nothing; imported by every module of the block
package ilt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KB_SHIFT    = 10;
    localparam int KB_W        = 32 - KB_SHIFT;

    // event kinds on the op field
    localparam logic [1:0] OP_QUEUE    = 2'd0;
    localparam logic [1:0] OP_MERGE    = 2'd1;
    localparam logic [1:0] OP_ISSUE    = 2'd2;
    localparam logic [1:0] OP_COMPLETE = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OFF     = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_COLLIDE = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // classified commands passed from front to back
    localparam logic [2:0] CMD_OFF      = 3'd0;
    localparam logic [2:0] CMD_QUEUE    = 3'd1;
    localparam logic [2:0] CMD_MERGE    = 3'd2;
    localparam logic [2:0] CMD_ISSUE    = 3'd3;
    localparam logic [2:0] CMD_COMPLETE = 3'd4;

    // configuration register word indexes
    localparam logic REG_TRACK = 1'b0;

    typedef struct packed {
        logic [2:0]      cmd;
        logic [63:0]     key;
        logic [KB_W-1:0] kb;
        logic [63:0]     stamp;
    } cmd_t;

    typedef struct packed {
        logic [63:0] latency;
        logic        latency_valid;
        logic [2:0]  status;
    } res_t;

endpackage

// ===== rtl/core/ilt_front.sv =====
// front end: takes trace words, classifies them and forms the lookup key
// depends on ilt_pkg; feeds ilt_cmd_queue
module ilt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    op,
    input  logic [63:0]   start_sector,
    input  logic [31:0]   byte_count,
    input  logic [63:0]   event_time,
    input  logic          fs_class,
    input  logic          tracking_enable,
    input  logic          q_full,
    output logic          q_push,
    output ilt_pkg::cmd_t q_data
);
    import ilt_pkg::*;

    logic            held_valid_reg, held_valid_next;
    logic [2:0]      cmd_reg;
    logic [63:0]     sector_reg;
    logic [KB_W-1:0] kb_reg;
    logic [63:0]     stamp_reg;
    logic [2:0]      cmd_in;
    logic            accept;

    always_comb
    begin
        if (!tracking_enable)
        begin
            cmd_in = CMD_OFF;
        end
        else
        begin
            unique case (op)
                OP_QUEUE:    cmd_in = CMD_QUEUE;
                OP_MERGE:    cmd_in = fs_class ? CMD_MERGE : CMD_OFF;
                OP_ISSUE:    cmd_in = fs_class ? CMD_ISSUE : CMD_OFF;
                OP_COMPLETE: cmd_in = fs_class ? CMD_COMPLETE : CMD_OFF;
                default:     cmd_in = CMD_OFF;
            endcase
        end
    end

    assign full   = held_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = held_valid_reg && !q_full;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (accept)
        begin
            held_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            held_valid_next = 1'b0;
        end
    end

    // merge looks up sector minus size in kilobytes
    always_comb
    begin
        q_data.cmd   = cmd_reg;
        q_data.kb    = kb_reg;
        q_data.stamp = stamp_reg;
        if (cmd_reg == CMD_MERGE)
        begin
            q_data.key = sector_reg - {{(64-KB_W){1'b0}}, kb_reg};
        end
        else
        begin
            q_data.key = sector_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_in;
            sector_reg <= start_sector;
            kb_reg     <= byte_count[31:KB_SHIFT];
            stamp_reg  <= event_time;
        end
    end

endmodule

// ===== rtl/core/ilt_cmd_queue.sv =====
// two-entry queue of classified commands between front and back
// depends on ilt_pkg
module ilt_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  ilt_pkg::cmd_t wr_data,
    output logic          q_full,
    input  logic          rd,
    output logic          q_empty,
    output ilt_pkg::cmd_t rd_data
);
    import ilt_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/ilt_res_queue.sv =====
// two-entry queue of result words on the output side
// depends on ilt_pkg
module ilt_res_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  ilt_pkg::res_t wr_data,
    output logic          q_full,
    input  logic          rd,
    output logic          q_empty,
    output ilt_pkg::res_t rd_data
);
    import ilt_pkg::*;

    res_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/ilt_back.sv =====
// back end: request table with parallel key compare, time memories, sequencer
// depends on ilt_pkg; reads ilt_cmd_queue and writes ilt_res_queue
module ilt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cq_empty,
    input  ilt_pkg::cmd_t cq_data,
    output logic          cq_pop,
    input  logic          rq_full,
    output logic          rq_push,
    output ilt_pkg::res_t rq_data
);
    import ilt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;

    logic [2:0]             state_reg, state_next;
    cmd_t                   cmd_reg;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [63:0]            sector_reg [TABLE_DEPTH];
    logic [63:0]            qtime_mem  [TABLE_DEPTH];
    logic [63:0]            dtime_mem  [TABLE_DEPTH];
    logic [63:0]            qtime_rd_reg, dtime_rd_reg;
    logic [63:0]            moved_reg;
    logic                   hit_reg, other_reg, free_any_reg;
    logic [IDX_W-1:0]       hit_idx_reg, free_idx_reg;

    logic [63:0]            cmp_key;
    logic [TABLE_DEPTH-1:0] match;
    logic                   match_any, free_any;
    logic [IDX_W-1:0]       match_idx, free_idx;

    logic                   sec_we;
    logic [IDX_W-1:0]       sec_addr;
    logic [63:0]            sec_wdata;
    logic                   qt_we, dt_we;
    logic [IDX_W-1:0]       qt_addr, dt_addr;
    logic [63:0]            dt_wdata;
    logic                   exec_go;

    // one shared compare network over every table entry
    assign cmp_key = (state_reg == S_MOVE) ? moved_reg : cmd_reg.key;

    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match[i] = valid_reg[i] && (sector_reg[i] == cmp_key);
        end
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign cq_pop  = (state_reg == S_IDLE) && !cq_empty;
    assign exec_go = (state_reg == S_EXEC) && !rq_full;
    assign rq_push = exec_go;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!cq_empty)
                begin
                    state_next = (cq_data.cmd == CMD_OFF) ? S_EXEC : S_LOOK;
                end
            end
            S_LOOK: state_next = (cmd_reg.cmd == CMD_MERGE) ? S_MOVE : S_READ;
            S_MOVE: state_next = S_EXEC;
            S_READ: state_next = S_EXEC;
            S_EXEC:
            begin
                if (!rq_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result and table updates in the execute step
    always_comb
    begin
        valid_next            = valid_reg;
        sec_we                = 1'b0;
        sec_addr              = hit_idx_reg;
        sec_wdata             = moved_reg;
        qt_we                 = 1'b0;
        qt_addr               = hit_idx_reg;
        dt_we                 = 1'b0;
        dt_addr               = hit_idx_reg;
        dt_wdata              = cmd_reg.stamp;
        rq_data.latency       = '0;
        rq_data.latency_valid = 1'b0;
        rq_data.status        = ST_OK;
        unique case (cmd_reg.cmd)
            CMD_QUEUE:
            begin
                if (hit_reg)
                begin
                    qt_we = exec_go;
                end
                else if (free_any_reg)
                begin
                    sec_addr  = free_idx_reg;
                    sec_wdata = cmd_reg.key;
                    sec_we    = exec_go;
                    qt_addr   = free_idx_reg;
                    qt_we     = exec_go;
                    dt_addr   = free_idx_reg;
                    dt_wdata  = '0;
                    dt_we     = exec_go;
                    if (exec_go)
                    begin
                        valid_next[free_idx_reg] = 1'b1;
                    end
                end
                else
                begin
                    rq_data.status = ST_FULL;
                end
            end
            CMD_MERGE:
            begin
                if (!hit_reg)
                begin
                    rq_data.status = ST_MISSING;
                end
                else if ((cmd_reg.kb != '0) && other_reg)
                begin
                    rq_data.status = ST_COLLIDE;
                    if (exec_go)
                    begin
                        valid_next[hit_idx_reg] = 1'b0;
                    end
                end
                else
                begin
                    sec_we = exec_go;
                end
            end
            CMD_ISSUE:
            begin
                if (!hit_reg)
                begin
                    rq_data.status = ST_MISSING;
                end
                else
                begin
                    dt_we                 = exec_go;
                    rq_data.latency       = cmd_reg.stamp - qtime_rd_reg;
                    rq_data.latency_valid = 1'b1;
                end
            end
            CMD_COMPLETE:
            begin
                if (!hit_reg)
                begin
                    rq_data.status = ST_MISSING;
                end
                else
                begin
                    rq_data.latency       = cmd_reg.stamp - dtime_rd_reg;
                    rq_data.latency_valid = 1'b1;
                    if (exec_go)
                    begin
                        valid_next[hit_idx_reg] = 1'b0;
                    end
                end
            end
            default: rq_data.status = ST_OFF;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cq_pop)
        begin
            cmd_reg <= cq_data;
        end
        if (state_reg == S_LOOK)
        begin
            hit_reg      <= match_any;
            hit_idx_reg  <= match_idx;
            free_any_reg <= free_any;
            free_idx_reg <= free_idx;
            moved_reg    <= cmd_reg.key - {{(64-KB_W){1'b0}}, cmd_reg.kb};
        end
        if (state_reg == S_MOVE)
        begin
            other_reg <= match_any;
        end
        if (sec_we)
        begin
            sector_reg[sec_addr] <= sec_wdata;
        end
    end

    // queue and dispatch time memories
    always_ff @(posedge clk)
    begin
        if (qt_we)
        begin
            qtime_mem[qt_addr] <= cmd_reg.stamp;
        end
        if (state_reg == S_READ)
        begin
            qtime_rd_reg <= qtime_mem[hit_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dt_we)
        begin
            dtime_mem[dt_addr] <= dt_wdata;
        end
        if (state_reg == S_READ)
        begin
            dtime_rd_reg <= dtime_mem[hit_idx_reg];
        end
    end

endmodule

// ===== rtl/core/io_request_latency_tracker.sv =====
// top level of the i/o request latency tracker
// depends on ilt_pkg, ilt_front, ilt_cmd_queue, ilt_back, ilt_res_queue
//
// trace event words enter through push/full and are taken when push is high
// and full is low. each word gives exactly one result word on the output
// queue: latency, latency_valid and status, shown while empty is low and
// taken when pop is high.
// an event passes the front register and command queue to the back end, which
// takes one event at a time and holds its word while the result queue is full:
// it takes the command, compares the key over all table entries, does one more
// compare for a merge or one registered read of the time memories, then the
// update and write-back step; an event reported as not tracked skips the middle.
// tracking_enable sits at byte address 0 of the apb port; the user must write it
// only while no event is in flight, the block itself does not enforce this.
// reset empties both queues, clears every table entry and turns tracking
// off. a stalled receiver fills the two-entry result queue, the back end
// then holds its finished word, and full rises once the command queue and
// the front register are occupied.
module io_request_latency_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  op,
    input  logic [63:0] start_sector,
    input  logic [31:0] byte_count,
    input  logic [63:0] event_time,
    input  logic        fs_class,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] latency,
    output logic        latency_valid,
    output logic [2:0]  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ilt_pkg::*;

    logic tracking_enable_reg, tracking_enable_next;
    logic cfg_wr;
    logic fq_push, cq_full, cq_empty, cq_pop;
    logic rq_push, rq_full;
    cmd_t fq_data, cq_data;
    res_t rq_wdata, rq_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TRACK);
    assign prdata = (paddr[2] == REG_TRACK) ? {31'b0, tracking_enable_reg} : 32'b0;
    assign tracking_enable_next = cfg_wr ? pwdata[0] : tracking_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_enable_reg <= 1'b0;
        end
        else
        begin
            tracking_enable_reg <= tracking_enable_next;
        end
    end

    ilt_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .op              (op),
        .start_sector    (start_sector),
        .byte_count      (byte_count),
        .event_time      (event_time),
        .fs_class        (fs_class),
        .tracking_enable (tracking_enable_reg),
        .q_full          (cq_full),
        .q_push          (fq_push),
        .q_data          (fq_data)
    );

    ilt_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (fq_push),
        .wr_data (fq_data),
        .q_full  (cq_full),
        .rd      (cq_pop),
        .q_empty (cq_empty),
        .rd_data (cq_data)
    );

    ilt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cq_empty (cq_empty),
        .cq_data  (cq_data),
        .cq_pop   (cq_pop),
        .rq_full  (rq_full),
        .rq_push  (rq_push),
        .rq_data  (rq_wdata)
    );

    ilt_res_queue u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (rq_push),
        .wr_data (rq_wdata),
        .q_full  (rq_full),
        .rd      (pop),
        .q_empty (empty),
        .rd_data (rq_rdata)
    );

    assign latency       = rq_rdata.latency;
    assign latency_valid = rq_rdata.latency_valid;
    assign status        = rq_rdata.status;

endmodule
